>>> rtl/scrc_pkg.sv
// ----------------------------------------------------------------------------
// scrc_pkg
// Shared types and constants for the shadow-cell race checker.
// ----------------------------------------------------------------------------
`default_nettype none
package scrc_pkg;

	localparam int unsigned EPOCH_W = 42;
	localparam int unsigned TID_W   = 4;
	localparam int unsigned BLK_W   = 10;
	localparam int unsigned OFF_W   = 3;
	localparam int unsigned POS_W   = 16;

	typedef enum logic {
		OP_ACCESS    = 1'b0,
		OP_CLK_WRITE = 1'b1
	} op_t;

	// input item
	typedef struct packed {
		logic               operation;
		logic [BLK_W-1:0]   block_index;
		logic [TID_W-1:0]   thread_id;
		logic [TID_W-1:0]   other_thread;
		logic [OFF_W-1:0]   byte_offset;
		logic               is_store;
		logic [POS_W-1:0]   code_position;
		logic [EPOCH_W-1:0] clock_value;
	} req_t;

	// result item
	typedef struct packed {
		logic               race_found;
		logic [TID_W-1:0]   prev_thread;
		logic [EPOCH_W-1:0] prev_epoch;
		logic [OFF_W-1:0]   prev_offset;
		logic               prev_is_store;
		logic [POS_W-1:0]   prev_code_position;
	} rsp_t;

	// queue status between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EVAL
	} bk_state_t;

endpackage
`default_nettype wire

>>> rtl/scrc_if.sv
// ----------------------------------------------------------------------------
// scrc_req_if / scrc_rsp_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface scrc_req_if;
	logic            valid;
	logic            ready;
	scrc_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface scrc_rsp_if;
	logic            valid;
	logic            ready;
	scrc_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/scrc_front.sv
// ----------------------------------------------------------------------------
// scrc_front
// Accepts items and queues them for the back end (two-entry queue).
// ----------------------------------------------------------------------------
`default_nettype none
module scrc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire scrc_pkg::req_t  in_data,
	input  wire logic            pop,
	output scrc_pkg::req_t       head,
	output scrc_pkg::q_stat_t    stat
);
	import scrc_pkg::*;

	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop_ok;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign in_ready   = !stat.full;
	assign push       = in_valid && in_ready;
	assign pop_ok     = pop && !stat.empty;
	assign head       = mem_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop_ok) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_ok};
		end
	end

endmodule
`default_nettype wire

>>> rtl/scrc_back.sv
// ----------------------------------------------------------------------------
// scrc_back
// Shadow block read-modify-write, vector clock store and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module scrc_back #(
	parameter int unsigned CELLS_PER_BLOCK = 4,
	parameter int unsigned SHADOW_BLOCKS   = 1024,
	parameter int unsigned THREADS         = 16,
	parameter int unsigned EPOCH_BITS      = 42
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scrc_pkg::req_t    head,
	input  wire scrc_pkg::q_stat_t stat,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output scrc_pkg::rsp_t         out_data
);
	import scrc_pkg::*;

	localparam int unsigned BA_W = (SHADOW_BLOCKS > 1) ? $clog2(SHADOW_BLOCKS) : 1;
	localparam int unsigned TH_W = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int unsigned CI_W = (CELLS_PER_BLOCK > 1) ? $clog2(CELLS_PER_BLOCK) : 1;
	localparam int unsigned CL_W = 2 * TH_W;
	// clock store is addressed by {row, column}, so it spans the full address range
	localparam int unsigned VC_D = 1 << CL_W;
	localparam int unsigned CLR_N = (SHADOW_BLOCKS > VC_D) ? SHADOW_BLOCKS : VC_D;
	localparam int unsigned CLR_W = $clog2(CLR_N) + 1;
	localparam int unsigned CW   = EPOCH_BITS + TH_W + OFF_W + 2;
	localparam logic [CI_W:0] LAST_CELL = (CI_W+1)'(CELLS_PER_BLOCK - 1);

	typedef struct packed {
		logic [EPOCH_BITS-1:0] epoch;
		logic [TH_W-1:0]       tid;
		logic [OFF_W-1:0]      off;
		logic                  wr;
		logic                  ign;
	} cell_t;

	typedef logic [CELLS_PER_BLOCK-1:0][CW-1:0]    row_t;
	typedef logic [CELLS_PER_BLOCK-1:0][POS_W-1:0] prow_t;

	// memories
	row_t                  cell_mem [SHADOW_BLOCKS];
	prow_t                 pos_mem  [SHADOW_BLOCKS];
	logic [CI_W-1:0]       vict_mem [SHADOW_BLOCKS];
	logic [EPOCH_BITS-1:0] vc_mem   [VC_D];
	logic [CLR_W-1:0]      clr_cnt_q;
	logic                  clr_q;

	bk_state_t             st_q, st_d;
	req_t                  cur_q;
	logic [BA_W-1:0]       blk_q;
	logic [TH_W-1:0]       tid_q;
	row_t                  row_s1;
	prow_t                 prow_s1;
	logic [CI_W-1:0]       vict_s1;
	logic [EPOCH_BITS-1:0] own_s1;
	logic [CI_W:0]         idx_q;
	logic                  stored_q;
	logic                  vc_rd_s1_pend;
	logic [EPOCH_BITS-1:0] vc_rd_s1;
	rsp_t                  rsp_q;
	logic                  rsp_v_q;

	logic need_vc, done, emit;
	logic hit_empty, hit_ign, hit_up, hit_race;

	logic [BA_W-1:0] blk_w;
	logic [TH_W-1:0] tid_w, oth_w;
	assign blk_w = BA_W'(head.block_index % SHADOW_BLOCKS);
	assign tid_w = TH_W'(head.thread_id % THREADS);
	assign oth_w = TH_W'(head.other_thread % THREADS);

	// scan state
	cell_t           c;
	cell_t           me;
	logic [CI_W-1:0] ci;
	logic [CL_W-1:0] vc_addr;
	assign ci = idx_q[CI_W-1:0];
	assign c  = cell_t'(row_s1[ci]);
	always_comb begin
		me.epoch = own_s1;
		me.tid   = tid_q;
		me.off   = cur_q.byte_offset;
		me.wr    = cur_q.is_store;
		me.ign   = 1'b0;
	end
	assign vc_addr = {tid_q, c.tid};

	logic rsp_free;
	assign rsp_free = !rsp_v_q || out_ready;

	// next state
	logic go;
	assign go = (st_q == BK_IDLE) && !stat.empty && !clr_q;
	always_comb begin
		st_d = st_q;
		pop  = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (go) begin
					pop = 1'b1;
					if (head.operation == OP_ACCESS) st_d = BK_READ;
				end
			end
			BK_READ: st_d = BK_EVAL;
			BK_EVAL: begin
				if (!vc_rd_s1_pend && rsp_free) begin
					if (done) st_d = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	// one cell per eval step; a vector clock lookup stalls the step until its read is registered
	always_comb begin
		need_vc   = 1'b0;
		hit_empty = 1'b0;
		hit_ign   = 1'b0;
		hit_up    = 1'b0;
		hit_race  = 1'b0;
		if (c.epoch == '0) begin
			hit_empty = !stored_q;
		end else if (c.off == me.off) begin
			if (c.ign) hit_ign = 1'b1;
			else if (c.tid == me.tid) hit_up = me.wr && !c.wr;
			else if (c.wr || me.wr) begin
				need_vc  = 1'b1;
				hit_race = vc_rd_s1 < c.epoch;
			end
		end
	end
	assign done = hit_ign || (hit_race && !vc_rd_s1_pend) || (idx_q == LAST_CELL);
	assign emit = (st_q == BK_EVAL) && !vc_rd_s1_pend && rsp_free && done;

	logic vc_fetched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= BK_IDLE;
			rsp_v_q      <= 1'b0;
			clr_q        <= 1'b1;
			clr_cnt_q    <= '0;
			vc_fetched_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CLR_W'(CLR_N - 1)) clr_q <= 1'b0;
			end
			if (emit) rsp_v_q <= 1'b1;
			else if (out_ready) rsp_v_q <= 1'b0;
			if (st_q == BK_EVAL && need_vc && !vc_fetched_q) vc_fetched_q <= 1'b1;
			else if (st_q == BK_EVAL && !vc_rd_s1_pend && rsp_free) vc_fetched_q <= 1'b0;
		end
	end
	assign vc_rd_s1_pend = need_vc && !vc_fetched_q && (st_q == BK_EVAL);

	// datapath: scan, row update and memories
	row_t  row_n;
	prow_t prow_n;
	cell_t ign_me;
	always_comb begin
		ign_me     = me;
		ign_me.ign = 1'b1;
		row_n      = row_s1;
		prow_n     = prow_s1;
		if (hit_empty || hit_up) begin
			row_n[ci]  = CW'(me);
			prow_n[ci] = cur_q.code_position;
		end else if (hit_race && !vc_rd_s1_pend) begin
			row_n[ci]  = CW'(ign_me);
			prow_n[ci] = cur_q.code_position;
		end
	end

	logic stored_n;
	assign stored_n = stored_q || hit_empty || hit_up || hit_race;

	// result item
	rsp_t rsp_n;
	always_comb begin
		rsp_n = '0;
		if (hit_race) begin
			rsp_n.race_found         = 1'b1;
			rsp_n.prev_thread        = TID_W'(c.tid);
			rsp_n.prev_epoch         = EPOCH_W'(c.epoch);
			rsp_n.prev_offset        = c.off;
			rsp_n.prev_is_store      = c.wr;
			rsp_n.prev_code_position = prow_s1[ci];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			if (clr_cnt_q < CLR_W'(SHADOW_BLOCKS)) begin
				cell_mem[clr_cnt_q[BA_W-1:0]] <= '0;
				vict_mem[clr_cnt_q[BA_W-1:0]] <= '0;
			end
			vc_mem[clr_cnt_q[CL_W-1:0]] <= '0;
		end
		if (go) begin
			cur_q <= head;
			blk_q <= blk_w;
			tid_q <= tid_w;
			if (head.operation == OP_CLK_WRITE)
				vc_mem[{tid_w, oth_w}] <= head.clock_value[EPOCH_BITS-1:0];
		end
		// read stage
		if (st_q == BK_READ) begin
			row_s1   <= cell_mem[blk_q];
			prow_s1  <= pos_mem[blk_q];
			vict_s1  <= vict_mem[blk_q];
			own_s1   <= vc_mem[{tid_q, tid_q}];
			idx_q    <= '0;
			stored_q <= 1'b0;
		end
		if (st_q == BK_EVAL) vc_rd_s1 <= vc_mem[vc_addr];
		// eval and write-back
		if (st_q == BK_EVAL && !vc_rd_s1_pend && rsp_free) begin
			row_s1   <= row_n;
			prow_s1  <= prow_n;
			stored_q <= stored_n;
			idx_q    <= idx_q + 1'b1;
			if (done && !hit_ign) begin
				if (stored_n) begin
					cell_mem[blk_q] <= row_n;
					pos_mem[blk_q]  <= prow_n;
				end else begin
					cell_mem[blk_q][vict_s1] <= CW'(me);
					pos_mem[blk_q][vict_s1]  <= cur_q.code_position;
					vict_mem[blk_q] <= (vict_s1 == CI_W'(CELLS_PER_BLOCK - 1)) ? '0 :
						CI_W'(vict_s1 + 1'b1);
				end
			end else if (hit_ign) begin
				// keep what the scan stored before the ignored cell
				cell_mem[blk_q] <= row_n;
				pos_mem[blk_q]  <= prow_n;
			end
			if (emit) rsp_q <= rsp_n;
		end
	end

	assign out_valid = rsp_v_q;
	assign out_data  = rsp_q;

endmodule
`default_nettype wire

>>> rtl/shadow_cell_race_check_unit.sv
// ----------------------------------------------------------------------------
// shadow_cell_race_check_unit
// Data-race checker over per-block shadow cells with vector clocks.
// ----------------------------------------------------------------------------
// an access is read in BK_READ, then its cells are scanned in BK_EVAL one per step, each
//   vector clock lookup and each rsp stall holding the scan; the result is registered
// the back end takes one item at a time; an access holds it through its read and its
//   scan, while a clock write is done in the cycle it is popped
// reset: after arst_n a clearing pass over SHADOW_BLOCKS entries (or the clock store depth
//   if larger) zeroes shadow cells, victim pointers and vector clocks
`default_nettype none
module shadow_cell_race_check_unit #(
	parameter int unsigned CELLS_PER_BLOCK = 4,
	parameter int unsigned SHADOW_BLOCKS   = 1024,
	parameter int unsigned THREADS         = 16,
	parameter int unsigned EPOCH_BITS      = 42
) (
	input  wire logic clk,
	input  wire logic arst_n,
	scrc_req_if.sink  req,
	scrc_rsp_if.source rsp
);
	import scrc_pkg::*;

	req_t    head;
	q_stat_t stat;
	logic    pop;

	scrc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.pop(pop), .head(head), .stat(stat)
	);

	scrc_back #(
		.CELLS_PER_BLOCK(CELLS_PER_BLOCK), .SHADOW_BLOCKS(SHADOW_BLOCKS),
		.THREADS(THREADS), .EPOCH_BITS(EPOCH_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .stat(stat), .pop(pop),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
	);

	// no race report carries a zero epoch
	a_race_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.race_found |-> rsp.data.prev_epoch != '0)
		else $error("race reported with empty cell");
	// quiet result is all zero; the check covers its epoch
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.race_found |-> rsp.data.prev_epoch == '0)
		else $error("nonzero fields without race");
	// queue never pops when empty
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop on empty queue");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shadow-cell race checker: a directed table
// followed by random access and clock-write items, checked against an
// in-bench model of the shadow store and vector clocks.
// ----------------------------------------------------------------------------
module tb_top;
	import scrc_pkg::*;

	localparam int unsigned CELLS   = 4;
	localparam int unsigned BLOCKS  = 1024;
	localparam int unsigned THREADS = 16;
	localparam int unsigned N_RAND  = 1700;
	localparam int unsigned LIMIT   = 600000;
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

	typedef struct {
		logic [EPOCH_W-1:0] epoch;
		logic [TID_W-1:0]   tid;
		logic [OFF_W-1:0]   off;
		bit                 wr;
		bit                 ign;
		logic [POS_W-1:0]   pos;
	} sh_cell_t;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	scrc_req_if req ();
	scrc_rsp_if rsp ();

	shadow_cell_race_check_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	sh_cell_t           shadow [BLOCKS][CELLS];
	logic [EPOCH_W-1:0] vclock [THREADS][THREADS];
	logic [1:0]         victim [BLOCKS];
	logic [EPOCH_W-1:0] own_epoch [THREADS];

	rsp_t race_q [$];
	row_t dir_rows [$];
	int   mismatches = 0;
	int   n_results = 0;
	int   n_races = 0;
	int   n_items = 0;
	int   cycles = 0;
	int   phase = 0;

	always #5 clk = ~clk;

	// model of one item; returns whether a result is due
	function automatic bit race_predict(input req_t r, output rsp_t o);
		sh_cell_t cur, c;
		bit stored;
		logic [1:0] v;
		o = '0;
		stored = 0;
		if (r.operation == OP_CLK_WRITE) begin
			vclock[r.thread_id][r.other_thread] = r.clock_value;
			return 0;
		end
		cur.epoch = vclock[r.thread_id][r.thread_id];
		cur.tid = r.thread_id;
		cur.off = r.byte_offset;
		cur.wr = r.is_store;
		cur.ign = 0;
		cur.pos = r.code_position;
		for (int i = 0; i < CELLS; i++) begin
			c = shadow[r.block_index][i];
			if (c.epoch == 0) begin
				if (!stored) begin
					shadow[r.block_index][i] = cur;
					stored = 1;
				end
				continue;
			end
			if (c.off != cur.off) continue;
			if (c.ign) return 1;
			if (c.tid == cur.tid) begin
				if (cur.wr && !c.wr) begin
					shadow[r.block_index][i] = cur;
					stored = 1;
				end
				continue;
			end
			if (!c.wr && !cur.wr) continue;
			if (vclock[r.thread_id][c.tid] >= c.epoch) continue;
			o.race_found = 1'b1;
			o.prev_thread = c.tid;
			o.prev_epoch = c.epoch;
			o.prev_offset = c.off;
			o.prev_is_store = c.wr;
			o.prev_code_position = c.pos;
			cur.ign = 1;
			shadow[r.block_index][i] = cur;
			stored = 1;
			break;
		end
		if (!stored) begin
			v = victim[r.block_index];
			shadow[r.block_index][v] = cur;
			victim[r.block_index] = v + 2'd1;
		end
		return 1;
	endfunction

	function automatic req_t mk_acc(int t, int b, int off, bit wr, int pos);
		req_t r;
		r = '0;
		r.operation = OP_ACCESS;
		r.thread_id = TID_W'(t);
		r.block_index = BLK_W'(b);
		r.byte_offset = OFF_W'(off);
		r.is_store = wr;
		r.code_position = POS_W'(pos);
		return r;
	endfunction

	function automatic req_t mk_clk(int t, int o, logic [EPOCH_W-1:0] val);
		req_t r;
		r = '0;
		r.operation = OP_CLK_WRITE;
		r.thread_id = TID_W'(t);
		r.other_thread = TID_W'(o);
		r.clock_value = val;
		return r;
	endfunction

	task automatic add_row(input req_t r, input bit typed, input rsp_t e);
		row_t w;
		w.r = r;
		w.typed = typed;
		w.e = e;
		dir_rows.push_back(w);
	endtask

	// random item, biased toward a few hot blocks and offsets so races happen
	function automatic req_t rand_item();
		req_t r;
		logic [95:0] raw;
		int k;
		raw = {$urandom, $urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		k = $urandom_range(0, 99);
		if (k < 18) begin
			r.operation = OP_CLK_WRITE;
			k = $urandom_range(0, 9);
			if (k < 5) begin
				r.other_thread = r.thread_id;
				own_epoch[r.thread_id] = own_epoch[r.thread_id] + $urandom_range(1, 3);
				r.clock_value = own_epoch[r.thread_id];
			end else if (k < 9) begin
				r.clock_value = own_epoch[r.other_thread] - $urandom_range(0, 2);
			end else if ($urandom_range(0, 1)) begin
				r.clock_value = EPOCH_MAX;
			end
		end else begin
			r.operation = OP_ACCESS;
			if ($urandom_range(0, 9) < 8) r.block_index = BLK_W'($urandom_range(0, 7));
			if ($urandom_range(0, 9) < 7) r.byte_offset = OFF_W'($urandom_range(0, 1));
		end
		return r;
	endfunction

	// put one item on the request channel and wait for it to be taken
	task automatic send_item(input req_t r);
		rsp_t o;
		req.valid <= 1'b1;
		req.data <= r;
		do @(negedge clk); while (!req.ready);
		@(posedge clk);
		n_items++;
		if (race_predict(r, o)) race_q.push_back(o);
	endtask

	task automatic sender_gap();
		int pct;
		pct = (phase == 0) ? 28 : (phase == 1) ? 72 : 0;
		if ($urandom_range(0, 99) < pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// receiver stalls
	always @(posedge clk) begin
		int pct;
		pct = (phase == 0) ? 72 : (phase == 1) ? 28 : 0;
		rsp.ready <= ($urandom_range(0, 99) >= pct);
	end

	// result check, sampled mid-cycle while the channel is stable
	always @(negedge clk) begin
		rsp_t e, a;
		if (arst_n && rsp.valid && rsp.ready) begin
			a = rsp.data;
			n_results++;
			if (race_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item %p", a);
			end else begin
				e = race_q.pop_front();
				if (e.race_found) n_races++;
				if (a.race_found !== e.race_found || a.prev_thread !== e.prev_thread ||
					a.prev_epoch !== e.prev_epoch || a.prev_offset !== e.prev_offset ||
					a.prev_is_store !== e.prev_is_store ||
					a.prev_code_position !== e.prev_code_position) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, a);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		rsp_t z, e;
		req_t r;
		z = '0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		for (int b = 0; b < BLOCKS; b++) begin
			victim[b] = 2'd0;
			for (int i = 0; i < CELLS; i++) shadow[b][i] = '{0, 0, 0, 0, 0, 0};
		end
		for (int t = 0; t < THREADS; t++) begin
			own_epoch[t] = '0;
			for (int u = 0; u < THREADS; u++) vclock[t][u] = '0;
		end

		// zero own epoch after reset, then a plain write-read race
		add_row(mk_acc(0, 0, 0, 0, 16'h0000), 1, z);
		add_row(mk_clk(1, 1, 42'd5), 0, z);
		add_row(mk_clk(2, 2, EPOCH_MAX), 0, z);
		add_row(mk_acc(1, 0, 0, 1, 16'h1111), 1, z);
		e = '{1'b1, 4'd1, 42'd5, 3'd0, 1'b1, 16'h1111};
		add_row(mk_acc(2, 0, 0, 0, 16'h2222), 1, e);
		// ignored cell at the same offset ends the check
		add_row(mk_acc(1, 0, 0, 1, 16'h0003), 1, z);
		// ordered by the clock: no race
		add_row(mk_clk(3, 3, 42'd7), 0, z);
		add_row(mk_clk(3, 1, 42'd5), 0, z);
		add_row(mk_acc(1, 1, 2, 1, 16'hAAAA), 0, z);
		add_row(mk_acc(3, 1, 2, 1, 16'hBBBB), 0, z);
		// read upgraded to write, racing with the other reader
		add_row(mk_acc(1, 2, 4, 0, 16'h0100), 0, z);
		add_row(mk_acc(3, 2, 4, 0, 16'h0200), 0, z);
		add_row(mk_acc(1, 2, 4, 1, 16'h0300), 0, z);
		// extremes of block, thread, offset, epoch and position
		add_row(mk_clk(15, 15, EPOCH_MAX), 0, z);
		add_row(mk_acc(15, 1023, 7, 1, 16'hFFFF), 1, z);
		e = '{1'b1, 4'd15, EPOCH_MAX, 3'd7, 1'b1, 16'hFFFF};
		add_row(mk_acc(0, 1023, 7, 0, 16'h0000), 1, e);
		// full block, round-robin victim replacement
		for (int k = 0; k < 6; k++) add_row(mk_acc(1, 3, k, 0, 16'h0400 + k), 0, z);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].r);
			if (dir_rows[i].typed && dir_rows[i].r.operation == OP_ACCESS)
				race_q[race_q.size()-1] = dir_rows[i].e;
		end
		req.valid <= 1'b0;
		@(posedge clk);
		// hold off until the block has drained
		while (race_q.size() != 0) @(posedge clk);

		// random items over three idling phases
		for (int n = 0; n < N_RAND; n++) begin
			phase = (n * 3) / N_RAND;
			if (n == N_RAND / 2) begin
				req.valid <= 1'b0;
				@(posedge clk);
				while (race_q.size() != 0) @(posedge clk);
			end else begin
				sender_gap();
			end
			r = rand_item();
			send_item(r);
		end
		req.valid <= 1'b0;

		while (race_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("%0d items sent, %0d results checked, %0d of them races",
			n_items, n_results, n_races);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0 && race_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
